FILE: hdl/normalized_blur_downsample_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the normalized blur / downsample block
// ----------------------------------------------------------------------------
`ifndef NORMALIZED_BLUR_DOWNSAMPLE_MACROS_SVH
`define NORMALIZED_BLUR_DOWNSAMPLE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define NBD_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted
`define NBD_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hdl/nbd_pkg.sv
// ----------------------------------------------------------------------------
// nbd_pkg
// Shared constants, types and mixing functions of the blur / downsample block.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package nbd_pkg;

    // Grid geometry
    localparam int SIDE       = 64;
    localparam int CNT_W      = $clog2(SIDE);
    localparam int LINE_DEPTH = SIDE / 2;
    localparam int ADDR_W     = $clog2(LINE_DEPTH);
    localparam int QUARTER    = SIDE / 4;
    localparam int LAST_ODD   = 2 * (SIDE / 2) - 1;

    // Divider geometry: dividend is a 32-bit sum times 65280
    localparam int DVD_W     = 48;
    localparam int STEP_W    = $clog2(DVD_W);
    localparam int DSR_W     = 24;
    localparam int NUM_LANES = 3;

    // Queue between front and back
    localparam int FIFO_DEPTH = 2;
    localparam int FPTR_W     = $clog2(FIFO_DEPTH);
    localparam int FCNT_W     = $clog2(FIFO_DEPTH + 1);

    // Q.8 constants
    localparam logic [23:0] SUM_MAX     = 24'd16646400;
    localparam logic [15:0] FULL_Q8     = 16'd65280;
    localparam logic [7:0]  W_EDGE_NEAR = 8'd169;
    localparam logic [7:0]  W_EDGE_FAR  = 8'd84;

    // Per-word classification done by the front
    typedef struct packed {
        logic              col_odd;
        logic              col_edge;
        logic              row_odd;
        logic              row_first;
        logic [ADDR_W-1:0] addr;
        logic [5:0]        dest_row;
        logic [5:0]        dest_col;
        logic              last;
    } tag_t;

    typedef struct packed {
        logic [31:0] luma_sum;
        logic [31:0] chroma_sum;
        logic [23:0] opacity_sum;
        logic [23:0] capacity_sum;
        tag_t        tag;
    } item_t;

    typedef struct packed {
        logic [23:0] luma;
        logic [23:0] chroma;
        logic [15:0] opacity;
        logic [15:0] capacity;
    } pix_t;

    localparam int PIX_W = $bits(pix_t);

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_HORZ,
        BK_VERT
    } back_state_t;

    // x * 65280 = (x << 16) - (x << 8)
    function automatic logic [DVD_W-1:0] scale_dividend(input logic [31:0] x);
        return {x, 16'b0} - {8'b0, x, 8'b0};
    endfunction

    function automatic logic [23:0] sat24(input logic [DVD_W-1:0] q,
                                          input logic [23:0] limit);
        return (q > DVD_W'(limit)) ? limit : q[23:0];
    endfunction

    // (169*near + 84*far) >> 8
    function automatic logic [23:0] edge24(input logic [23:0] near, input logic [23:0] far);
        logic [32:0] s;
        s = 33'(near) * 33'(W_EDGE_NEAR) + 33'(far) * 33'(W_EDGE_FAR);
        return s[31:8];
    endfunction

    // (64a + 128b + 64c) >> 8 == (a + 2b + c) >> 2
    function automatic logic [23:0] mid24(input logic [23:0] a, input logic [23:0] b,
                                          input logic [23:0] c);
        logic [25:0] s;
        s = 26'(a) + {1'b0, b, 1'b0} + 26'(c);
        return s[25:2];
    endfunction

    function automatic pix_t edge_pix(input pix_t near, input pix_t far);
        pix_t p;
        p.luma     = edge24(near.luma, far.luma);
        p.chroma   = edge24(near.chroma, far.chroma);
        p.opacity  = 16'(edge24(24'(near.opacity), 24'(far.opacity)));
        p.capacity = 16'(edge24(24'(near.capacity), 24'(far.capacity)));
        return p;
    endfunction

    function automatic pix_t mid_pix(input pix_t a, input pix_t b, input pix_t c);
        pix_t p;
        p.luma     = mid24(a.luma, b.luma, c.luma);
        p.chroma   = mid24(a.chroma, b.chroma, c.chroma);
        p.opacity  = 16'(mid24(24'(a.opacity), 24'(b.opacity), 24'(c.opacity)));
        p.capacity = 16'(mid24(24'(a.capacity), 24'(b.capacity), 24'(c.capacity)));
        return p;
    endfunction

endpackage

FILE: hdl/nbd_ram.sv
// ----------------------------------------------------------------------------
// nbd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nbd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/nbd_front.sv
// ----------------------------------------------------------------------------
// nbd_front
// Accepts input words, tracks the raster position and tags each word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nbd_front
    import nbd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_luma_sum,
    input  logic [31:0] s_chroma_sum,
    input  logic [23:0] s_opacity_sum,
    input  logic [23:0] s_capacity_sum,
    input  logic        fifo_full,
    output logic        push,
    output item_t       push_item
);

    logic [CNT_W-1:0] row_reg, row_next;
    logic [CNT_W-1:0] col_reg, col_next;
    tag_t             tag;

    assign s_ready = !fifo_full;
    assign push    = s_valid && s_ready;

    // Classify the word from its position
    always_comb begin
        tag.col_odd   = col_reg[0];
        tag.col_edge  = (col_reg == CNT_W'(1));
        tag.row_odd   = row_reg[0];
        tag.row_first = (row_reg == CNT_W'(1));
        tag.addr      = ADDR_W'(col_reg >> 1);
        tag.dest_row  = 6'(QUARTER + int'(row_reg >> 1));
        tag.dest_col  = 6'(QUARTER + int'(col_reg >> 1));
        tag.last      = (row_reg == CNT_W'(LAST_ODD)) && (col_reg == CNT_W'(LAST_ODD));
    end

    assign push_item = '{luma_sum:     s_luma_sum,
                         chroma_sum:   s_chroma_sum,
                         opacity_sum:  s_opacity_sum,
                         capacity_sum: s_capacity_sum,
                         tag:          tag};

    // Raster counters, wrap at frame end
    always_comb begin
        row_next = row_reg;
        col_next = col_reg;
        if (push) begin
            if (col_reg == CNT_W'(SIDE - 1)) begin
                col_next = '0;
                row_next = (row_reg == CNT_W'(SIDE - 1)) ? '0 : row_reg + 1'b1;
            end else begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            row_reg <= '0;
            col_reg <= '0;
        end else begin
            row_reg <= row_next;
            col_reg <= col_next;
        end
    end

endmodule

FILE: hdl/nbd_fifo.sv
// ----------------------------------------------------------------------------
// nbd_fifo
// Two-entry queue of tagged words between front and back.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module nbd_fifo
    import nbd_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  push,
    input  item_t push_item,
    output logic  full,
    input  logic  pop,
    output logic  head_valid,
    output item_t head_item
);

    item_t             mem_reg [FIFO_DEPTH];
    logic [FPTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FCNT_W-1:0] count_reg, count_next;

    assign full       = (count_reg == FCNT_W'(FIFO_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_item  = mem_reg[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    // Storage
    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_item;
        end
    end

    // Pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

FILE: hdl/nbd_div.sv
// ----------------------------------------------------------------------------
// nbd_div
// Three-lane restoring divider with a shared divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "normalized_blur_downsample_macros.svh"

module nbd_div
    import nbd_pkg::*;
(
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [DVD_W-1:0] dvd_in [NUM_LANES],
    input  logic [DSR_W-1:0] dsr_in,
    output logic             done,
    output logic [DVD_W-1:0] quo    [NUM_LANES]
);

    logic [DVD_W-1:0]  dvd_reg [NUM_LANES];
    logic [DVD_W-1:0]  dvd_next [NUM_LANES];
    logic [DSR_W-1:0]  rem_reg [NUM_LANES];
    logic [DSR_W-1:0]  rem_next [NUM_LANES];
    logic [DSR_W-1:0]  dsr_reg;
    logic [STEP_W-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;
    logic [DSR_W:0]    trial [NUM_LANES];
    logic              fits [NUM_LANES];

    // One compare-subtract step per lane; quotient bits shift in from the bottom
    always_comb begin
        for (int k = 0; k < NUM_LANES; k++) begin
            trial[k]    = {rem_reg[k], dvd_reg[k][DVD_W-1]};
            fits[k]     = (trial[k] >= {1'b0, dsr_reg});
            rem_next[k] = fits[k] ? DSR_W'(trial[k] - {1'b0, dsr_reg}) : trial[k][DSR_W-1:0];
            dvd_next[k] = {dvd_reg[k][DVD_W-2:0], fits[k]};
        end
    end

    // Datapath
    always_ff @(posedge aclk) begin
        if (start) begin
            dsr_reg <= dsr_in;
            for (int k = 0; k < NUM_LANES; k++) begin
                dvd_reg[k] <= dvd_in[k];
                rem_reg[k] <= '0;
            end
        end else if (busy_reg) begin
            for (int k = 0; k < NUM_LANES; k++) begin
                dvd_reg[k] <= dvd_next[k];
                rem_reg[k] <= rem_next[k];
            end
        end
    end

    // Step counter
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == STEP_W'(DVD_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done = done_reg;
    assign quo  = dvd_reg;

    `NBD_ASSERT_NOW(a_no_restart, aclk, aresetn, busy_reg, !start, "divider restarted while busy")
    `NBD_ASSERT_NEXT(a_done_pulse, aclk, aresetn, done_reg, !done_reg && !busy_reg, "done not a single pulse")
    `NBD_ASSERT_NOW(a_done_excl, aclk, aresetn, done_reg, !busy_reg, "done while still stepping")

endmodule

FILE: hdl/nbd_back.sv
// ----------------------------------------------------------------------------
// nbd_back
// Normalizes a queued word, runs the horizontal and vertical blur through the
// two line buffers and holds emitted words in the output register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

`include "normalized_blur_downsample_macros.svh"

module nbd_back
    import nbd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        head_valid,
    input  item_t       head_item,
    output logic        pop,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [23:0] m_luma_out,
    output logic [23:0] m_chroma_out,
    output logic [15:0] m_opacity_out,
    output logic [15:0] m_capacity_out,
    output logic [5:0]  m_dest_row,
    output logic [5:0]  m_dest_col,
    output logic        m_frame_last
);

    back_state_t state_reg, state_next;
    item_t       cur_reg;
    pix_t        n_reg, hw0_reg, hw1_reg, hb_reg, out_reg;
    pix_t        n_calc, hb_calc, v_calc;
    logic [5:0]  dest_row_reg, dest_col_reg;
    logic        last_reg;
    logic        m_valid_reg, m_valid_next;

    logic             div_start, div_done;
    logic [DVD_W-1:0] dvd [NUM_LANES];
    logic [DVD_W-1:0] quo [NUM_LANES];

    logic              even_wr, odd_wr, line_rd;
    pix_t              even_rd, odd_rd;
    logic [PIX_W-1:0]  even_rd_bits, odd_rd_bits;

    logic load_n, load_hb, shift_win, load_out, out_busy, emit;

    assign dvd[0] = scale_dividend(head_item.luma_sum);
    assign dvd[1] = scale_dividend(head_item.chroma_sum);
    assign dvd[2] = scale_dividend({8'b0, head_item.opacity_sum});

    nbd_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .dvd_in  (dvd),
        .dsr_in  (head_item.capacity_sum),
        .done    (div_done),
        .quo     (quo)
    );

    // Line of even rows and line of odd rows, even columns only
    nbd_ram #(.WIDTH(PIX_W), .DEPTH(LINE_DEPTH)) u_even_line (
        .aclk    (aclk),
        .wr_en   (even_wr),
        .wr_addr (cur_reg.tag.addr),
        .wr_data (hb_reg),
        .rd_en   (line_rd),
        .rd_addr (cur_reg.tag.addr),
        .rd_data (even_rd_bits)
    );

    nbd_ram #(.WIDTH(PIX_W), .DEPTH(LINE_DEPTH)) u_odd_line (
        .aclk    (aclk),
        .wr_en   (odd_wr),
        .wr_addr (cur_reg.tag.addr),
        .wr_data (hb_reg),
        .rd_en   (line_rd),
        .rd_addr (cur_reg.tag.addr),
        .rd_data (odd_rd_bits)
    );

    assign even_rd = pix_t'(even_rd_bits);
    assign odd_rd  = pix_t'(odd_rd_bits);

    // Saturate quotients; an empty cell has zero content
    always_comb begin
        if (cur_reg.capacity_sum == '0) begin
            n_calc.luma    = '0;
            n_calc.chroma  = '0;
            n_calc.opacity = '0;
        end else begin
            n_calc.luma    = sat24(quo[0], SUM_MAX);
            n_calc.chroma  = sat24(quo[1], SUM_MAX);
            n_calc.opacity = 16'(sat24(quo[2], 24'(FULL_Q8)));
        end
        n_calc.capacity = FULL_Q8;
    end

    // Horizontal and vertical taps
    assign hb_calc = cur_reg.tag.col_edge ? edge_pix(hw0_reg, n_reg)
                                          : mid_pix(hw1_reg, hw0_reg, n_reg);
    assign v_calc  = cur_reg.tag.row_first ? edge_pix(even_rd, hb_reg)
                                           : mid_pix(odd_rd, even_rd, hb_reg);

    assign out_busy = m_valid_reg && !m_ready;
    assign emit     = cur_reg.tag.col_odd && cur_reg.tag.row_odd;

    // Sequencer
    always_comb begin
        state_next = state_reg;
        pop        = 1'b0;
        div_start  = 1'b0;
        load_n     = 1'b0;
        load_hb    = 1'b0;
        line_rd    = 1'b0;
        even_wr    = 1'b0;
        odd_wr     = 1'b0;
        shift_win  = 1'b0;
        load_out   = 1'b0;
        unique case (state_reg)
            BK_IDLE: begin
                if (head_valid) begin
                    pop        = 1'b1;
                    div_start  = 1'b1;
                    state_next = BK_DIV;
                end
            end
            BK_DIV: begin
                if (div_done) begin
                    load_n     = 1'b1;
                    state_next = cur_reg.tag.col_odd ? BK_HORZ : BK_VERT;
                end
            end
            BK_HORZ: begin
                load_hb    = 1'b1;
                line_rd    = 1'b1;
                state_next = BK_VERT;
            end
            BK_VERT: begin
                if (!(emit && out_busy)) begin
                    shift_win  = 1'b1;
                    even_wr    = cur_reg.tag.col_odd && !cur_reg.tag.row_odd;
                    odd_wr     = emit;
                    load_out   = emit;
                    state_next = BK_IDLE;
                end
            end
            default: state_next = BK_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (pop) begin
            cur_reg <= head_item;
        end
        if (load_n) begin
            n_reg <= n_calc;
        end
        if (load_hb) begin
            hb_reg <= hb_calc;
        end
        if (shift_win) begin
            hw1_reg <= hw0_reg;
            hw0_reg <= n_reg;
        end
        if (load_out) begin
            out_reg      <= v_calc;
            dest_row_reg <= cur_reg.tag.dest_row;
            dest_col_reg <= cur_reg.tag.dest_col;
            last_reg     <= cur_reg.tag.last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_luma_out     = out_reg.luma;
    assign m_chroma_out   = out_reg.chroma;
    assign m_opacity_out  = out_reg.opacity;
    assign m_capacity_out = out_reg.capacity;
    assign m_dest_row     = dest_row_reg;
    assign m_dest_col     = dest_col_reg;
    assign m_frame_last   = last_reg;

    `NBD_ASSERT_NOW(a_done_in_div, aclk, aresetn, div_done, state_reg == BK_DIV, "divider finished outside divide state")
    `NBD_ASSERT_NEXT(a_div_wait, aclk, aresetn, (state_reg == BK_DIV) && !div_done, state_reg == BK_DIV, "left divide state early")
    `NBD_ASSERT_NOW(a_read_before_use, aclk, aresetn, (state_reg == BK_VERT) && emit, ($past(state_reg) == BK_HORZ) || ($past(state_reg) == BK_VERT), "line data used without a read")

endmodule

FILE: hdl/normalized_blur_downsample.sv
// ----------------------------------------------------------------------------
// normalized_blur_downsample
// Normalizes accumulator cells, blurs them 3x3 and emits the 2x decimated grid.
//
//   channel  dir  handshake           words
//   s_       in   s_valid / s_ready   one cell per word, raster order
//   m_       out  m_valid / m_ready   one word per even-row, even-column cell
//
// The back end takes one cell at a time and normalizes it with the 48-step
// restoring divider, running luma, chroma and opacity in three lanes.
// The front takes words while the two-entry queue has room.
// Reset is synchronous, active low; it clears the raster position, the queue,
// the sequencer and the output valid. Line buffers are not cleared.
// A stalled output word holds the back end only on a cell that emits.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module normalized_blur_downsample
    import nbd_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [31:0] s_luma_sum,
    input  logic [31:0] s_chroma_sum,
    input  logic [23:0] s_opacity_sum,
    input  logic [23:0] s_capacity_sum,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [23:0] m_luma_out,
    output logic [23:0] m_chroma_out,
    output logic [15:0] m_opacity_out,
    output logic [15:0] m_capacity_out,
    output logic [5:0]  m_dest_row,
    output logic [5:0]  m_dest_col,
    output logic        m_frame_last
);

    logic  push, pop, fifo_full, head_valid;
    item_t push_item, head_item;

    nbd_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_luma_sum     (s_luma_sum),
        .s_chroma_sum   (s_chroma_sum),
        .s_opacity_sum  (s_opacity_sum),
        .s_capacity_sum (s_capacity_sum),
        .fifo_full      (fifo_full),
        .push           (push),
        .push_item      (push_item)
    );

    nbd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (push),
        .push_item  (push_item),
        .full       (fifo_full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_item  (head_item)
    );

    nbd_back u_back (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .head_valid     (head_valid),
        .head_item      (head_item),
        .pop            (pop),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_luma_out     (m_luma_out),
        .m_chroma_out   (m_chroma_out),
        .m_opacity_out  (m_opacity_out),
        .m_capacity_out (m_capacity_out),
        .m_dest_row     (m_dest_row),
        .m_dest_col     (m_dest_col),
        .m_frame_last   (m_frame_last)
    );

endmodule

FILE: tb/tb_normalized_blur_downsample.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_normalized_blur_downsample
// Streams accumulator cells through the blur / downsample block over a large
// part of a frame. A scoreboard tracks the normalize, blur and decimate
// arithmetic and checks every output word in order, field by field.
// ----------------------------------------------------------------------------

module tb_normalized_blur_downsample;
    import nbd_pkg::*;

    typedef struct {
        bit [23:0] luma;
        bit [23:0] chroma;
        bit [15:0] opacity;
        bit [15:0] capacity;
        bit [5:0]  dest_row;
        bit [5:0]  dest_col;
        bit        last;
    } blur_word_t;

    // Tracks raster position, the horizontal window and both line stores
    class blur_scoreboard;
        bit [31:0]  row_pos;
        bit [31:0]  col_pos;
        bit [63:0]  window[4][2];
        bit [63:0]  hlines[4][2*SIDE];
        blur_word_t pending[$];
        int         errors;

        function bit [63:0] edge_sum(bit [63:0] near, bit [63:0] far);
            return (64'd169 * near + 64'd84 * far) >> 8;
        endfunction

        function bit [63:0] mid_sum(bit [63:0] a, bit [63:0] b, bit [63:0] c);
            return (64'd64 * a + 64'd128 * b + 64'd64 * c) >> 8;
        endfunction

        function bit [63:0] scale(bit [63:0] x, bit [63:0] cap, bit [63:0] limit);
            bit [63:0] q;
            q = (x * 64'd65280) / cap;
            return (q > limit) ? limit : q;
        endfunction

        // Accepted cell: normalize, blur, and queue a word on odd/odd steps
        function void note_cell(bit [31:0] luma, bit [31:0] chroma,
                                bit [23:0] opac, bit [23:0] cap);
            bit [63:0]  n[4];
            bit [63:0]  v[4];
            bit [63:0]  hb;
            bit [31:0]  cc;
            blur_word_t w;
            if (cap == 0) begin
                n[0] = 0; n[1] = 0; n[2] = 0;
            end else begin
                n[0] = scale(luma, cap, 64'd16646400);
                n[1] = scale(chroma, cap, 64'd16646400);
                n[2] = scale(opac, cap, 64'd65280);
            end
            n[3] = 64'd65280;
            if (col_pos[0]) begin
                cc = col_pos - 1;
                for (int k = 0; k < 4; k++) begin
                    if (cc == 0) hb = edge_sum(window[k][0], n[k]);
                    else hb = mid_sum(window[k][1], window[k][0], n[k]);
                    if (!row_pos[0]) begin
                        hlines[k][cc] = hb;
                    end else begin
                        v[k] = (row_pos == 1) ? edge_sum(hlines[k][cc], hb)
                             : mid_sum(hlines[k][SIDE+cc], hlines[k][cc], hb);
                        hlines[k][SIDE+cc] = hb;
                    end
                end
                if (row_pos[0]) begin
                    w.luma     = v[0][23:0];
                    w.chroma   = v[1][23:0];
                    w.opacity  = v[2][15:0];
                    w.capacity = v[3][15:0];
                    w.dest_row = 6'(SIDE / 4 + (row_pos >> 1));
                    w.dest_col = 6'(SIDE / 4 + (col_pos >> 1));
                    w.last     = (row_pos == LAST_ODD) && (col_pos == LAST_ODD);
                    pending.push_back(w);
                end
            end
            for (int k = 0; k < 4; k++) begin
                window[k][1] = window[k][0];
                window[k][0] = n[k];
            end
            col_pos++;
            if (col_pos >= SIDE) begin
                col_pos = 0;
                row_pos++;
                if (row_pos >= SIDE) row_pos = 0;
            end
        endfunction

        function void field_check(string name, bit [31:0] exp_v, bit [31:0] act_v);
            if (exp_v !== act_v) begin
                $display("%0t mismatch %s expected %0d actual %0d", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        // Output word: compare with the oldest expectation
        function void check_word(blur_word_t act);
            blur_word_t e;
            if (pending.size() == 0) begin
                $display("%0t unexpected word expected none actual row %0d col %0d",
                         $time, act.dest_row, act.dest_col);
                errors++;
                return;
            end
            e = pending.pop_front();
            field_check("luma_out", e.luma, act.luma);
            field_check("chroma_out", e.chroma, act.chroma);
            field_check("opacity_out", e.opacity, act.opacity);
            field_check("capacity_out", e.capacity, act.capacity);
            field_check("dest_row", e.dest_row, act.dest_row);
            field_check("dest_col", e.dest_col, act.dest_col);
            field_check("frame_last", e.last, act.last);
        endfunction
    endclass

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [31:0] s_luma_sum = '0;
    logic [31:0] s_chroma_sum = '0;
    logic [23:0] s_opacity_sum = '0;
    logic [23:0] s_capacity_sum = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [23:0] m_luma_out;
    logic [23:0] m_chroma_out;
    logic [15:0] m_opacity_out;
    logic [15:0] m_capacity_out;
    logic [5:0]  m_dest_row;
    logic [5:0]  m_dest_col;
    logic        m_frame_last;

    blur_scoreboard sb = new();
    bit burst_in;
    bit burst_out;
    int words_seen;

    normalized_blur_downsample dut (.*);

    initial begin
        forever #10 aclk = ~aclk;
    end

    initial begin
        #40_000_000;
        $display("status: fail");
        $finish;
    end

    // Present one cell after a random gap, hold until accepted
    task automatic send_cell(bit [31:0] l, bit [31:0] c, bit [23:0] o, bit [23:0] cap);
        int gap;
        gap = burst_in ? 0 : $urandom_range(13, 0);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid        <= 1'b1;
        s_luma_sum     <= l;
        s_chroma_sum   <= c;
        s_opacity_sum  <= o;
        s_capacity_sum <= cap;
        do @(posedge aclk); while (!s_ready);
        sb.note_cell(l, c, o, cap);
        @(negedge aclk);
    endtask

    // Random cell: mostly consistent sums, some empty cells, some raw noise
    task automatic send_random;
        bit [23:0] cap;
        bit [63:0] top;
        int kind;
        kind = $urandom_range(99, 0);
        cap = ($urandom_range(1, 0)) ? 24'($urandom_range(300, 1)) : 24'($urandom);
        if (cap == 0) cap = 1;
        top = 64'd255 * cap;
        if (top > 64'hFF000000) top = 64'hFF000000;
        if (kind < 60)
            send_cell($urandom_range(top[31:0], 0), $urandom_range(top[31:0], 0),
                      24'($urandom_range(cap, 0)), cap);
        else if (kind < 70)
            send_cell($urandom_range(32'hFF000000, 0), $urandom_range(32'hFF000000, 0),
                      24'($urandom), 24'd0);
        else
            send_cell($urandom_range(32'hFF000000, 0), $urandom_range(32'hFF000000, 0),
                      24'($urandom), 24'($urandom));
    endtask

    // Sender: directed corners, then random cells over many rows
    initial begin
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);
        send_cell(0, 0, 0, 0);
        send_cell(32'hFF000000, 32'hFF000000, 24'hFFFFFF, 24'hFFFFFF);
        send_cell(32'hFF000000, 32'hFF000000, 24'hFFFFFF, 0);
        send_cell(32'hFF000000, 32'hFF000000, 24'hFFFFFF, 1);
        send_cell(255, 255, 1, 1);
        send_cell(32'h00FFFFFF, 0, 24'h800000, 24'h000100);
        send_cell(0, 32'h00FFFFFF, 0, 24'hFFFFFF);
        send_cell(32'hAAAAAAAA, 32'h55555555, 24'hAAAAAA, 24'h555555);
        send_cell(32'h55555555, 32'hAAAAAAAA, 24'h555555, 24'hAAAAAA);
        send_cell(32'hFEFFFFFF, 32'h7F000000, 24'hFFFFFE, 24'hFFFFFF);
        send_cell(1, 1, 1, 24'hFFFFFF);
        send_cell(32'hFF000000, 0, 0, 24'hFFFFFF);
        send_cell(0, 0, 0, 24'h000001);
        send_cell(12345, 999, 7, 24'h000003);
        send_cell(32'h0000FF00, 32'h0000FF00, 24'h000100, 24'h000100);
        send_cell(32'h00000001, 32'hFF000000, 24'h000002, 24'h000002);
        for (int i = 0; i < 1734; i++) begin
            if (i % 60 == 0) burst_in = ($urandom_range(3, 0) == 0);
            // drain fully once, mid-run
            if (i == 700) begin
                s_valid <= 1'b0;
                while (sb.pending.size() != 0) @(negedge aclk);
            end
            send_random();
        end
        s_valid <= 1'b0;
        while (sb.pending.size() != 0) @(negedge aclk);
        repeat (120) @(negedge aclk);
        if (sb.errors == 0 && sb.pending.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    // Receiver: random stalls, one long hold-off to back up the input
    initial begin
        int stall;
        blur_word_t w;
        @(posedge aresetn);
        forever begin
            @(negedge aclk);
            if (words_seen % 50 == 0) burst_out = ($urandom_range(3, 0) == 0);
            stall = burst_out ? 0 : $urandom_range(13, 0);
            if (words_seen == 40) stall = 3000;
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            w.luma     = m_luma_out;
            w.chroma   = m_chroma_out;
            w.opacity  = m_opacity_out;
            w.capacity = m_capacity_out;
            w.dest_row = m_dest_row;
            w.dest_col = m_dest_col;
            w.last     = m_frame_last;
            sb.check_word(w);
            words_seen++;
        end
    end

endmodule
